// File: hw/rtl/rwc_pkg.sv
// ----------------------------------------------------------------------------
// Replay window check package
// Shared sizes, register indexes, verdict codes and configuration type.
// ----------------------------------------------------------------------------
package rwc_pkg;

    // Number of bits held in the arrival bitmap.
    localparam int WINDOW_MAX = 64;

    // Index into the bitmap, also wide enough for any in-range shift amount.
    localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

    localparam int SEQ_W  = 32;
    localparam int WIN_W  = 7;
    localparam int CFG_W  = 7;
    localparam int CIDX_W = 1;

    localparam logic [SEQ_W-1:0] WINDOW_MAX_SEQ = SEQ_W'(WINDOW_MAX);

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] REG_RX_ENABLE   = 1'd0;
    localparam logic [CIDX_W-1:0] REG_WINDOW_SIZE = 1'd1;

    typedef enum logic [1:0] {
        VERDICT_ACCEPT = 2'd0,
        VERDICT_OLD    = 2'd1,
        VERDICT_DUP    = 2'd2
    } t_verdict;

    typedef struct packed {
        logic             rx_enable;
        logic [WIN_W-1:0] window_size;
    } t_cfg;

endpackage

// File: hw/rtl/rwc_window.sv
// ----------------------------------------------------------------------------
// Replay window state and check
// Holds the highest sequence number and the arrival bitmap, and judges one
// word per cycle against them, updating them only when i_fire is high.
// ----------------------------------------------------------------------------
module rwc_window import rwc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic [SEQ_W-1:0] i_seq,
    input  t_cfg             i_cfg,
    output t_verdict         o_verdict
);

    logic [SEQ_W-1:0]      r_highest;
    logic [SEQ_W-1:0]      n_highest;
    logic [WINDOW_MAX-1:0] r_bitmap;
    logic [WINDOW_MAX-1:0] n_bitmap;

    logic                  enabled;
    logic                  newer;
    logic [SEQ_W-1:0]      ahead;
    logic [SEQ_W-1:0]      behind;
    logic                  in_window;
    logic [IDX_W-1:0]      pos;
    logic [WINDOW_MAX-1:0] shifted;

    assign enabled   = i_cfg.rx_enable && (i_cfg.window_size != '0);
    assign newer     = i_seq > r_highest;
    assign ahead     = i_seq - r_highest;
    assign behind    = r_highest - i_seq;
    // Distance must be below both the programmed window and the bitmap length.
    assign in_window = (behind < {{(SEQ_W-WIN_W){1'b0}}, i_cfg.window_size})
                    && (behind < WINDOW_MAX_SEQ);
    assign pos       = behind[IDX_W-1:0];
    assign shifted   = (ahead >= WINDOW_MAX_SEQ) ? '0 : (r_bitmap << ahead[IDX_W-1:0]);

    always_comb begin
        o_verdict = VERDICT_ACCEPT;
        n_highest = r_highest;
        n_bitmap  = r_bitmap;
        if (enabled) begin
            if (newer) begin
                // A newer number is never a duplicate: bit 0 is clear after the shift.
                n_highest   = i_seq;
                n_bitmap    = shifted;
                n_bitmap[0] = 1'b1;
            end else if (!in_window) begin
                o_verdict = VERDICT_OLD;
            end else if (r_bitmap[pos]) begin
                o_verdict = VERDICT_DUP;
            end else begin
                n_bitmap[pos] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_highest <= '0;
            r_bitmap  <= '0;
        end else if (i_fire) begin
            r_highest <= n_highest;
            r_bitmap  <= n_bitmap;
        end
    end

    a_newer_becomes_highest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && i_fire && enabled && newer |=> r_highest == $past(i_seq))
        else $error("newer sequence number did not become the highest");

    a_disabled_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && i_fire && !enabled |=> $stable(r_highest) && $stable(r_bitmap))
        else $error("state changed while checking was disabled");

    a_highest_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && i_fire |=> r_highest >= $past(r_highest))
        else $error("highest sequence number went backwards");

    a_reject_keeps_bitmap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && i_fire && (o_verdict != VERDICT_ACCEPT)
        |=> $stable(r_bitmap) && $stable(r_highest))
        else $error("rejected word changed the window state");

endmodule

// File: hw/rtl/replay_window_check.sv
// ----------------------------------------------------------------------------
// Replay window check
// Anti-replay sliding window: judges each received sequence number as
// accepted, too old or duplicate.
// ----------------------------------------------------------------------------
// Path: an accepted word waits in the input register; the check then writes
// its verdict into the output register. One word per cycle unless the verdict
// side stalls; the window compare, the bitmap shift and the bit test all sit
// between the input register and the state/verdict registers.
// Reset (synchronous, active low) clears the highest number, the bitmap, both
// configuration registers and the valid flags; no clearing pass is needed.
// ----------------------------------------------------------------------------
module replay_window_check import rwc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Configuration write port
    input  logic              i_cfg_wr_en,
    input  logic [CIDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    // Sequence number words in
    input  logic              i_seq_valid,
    output logic              o_seq_ready,
    input  logic [SEQ_W-1:0]  i_seq_number,
    // Verdict words out
    output logic              o_verdict_valid,
    input  logic              i_verdict_ready,
    output logic [1:0]        o_verdict
);

    // Configuration registers. The user must write only while the block is idle;
    // the block does not enforce it, and the check logic reads them directly.
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_RX_ENABLE:   r_cfg.rx_enable   <= i_cfg_wdata[0];
                REG_WINDOW_SIZE: r_cfg.window_size <= i_cfg_wdata[WIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Two-register pipeline: input register, then the verdict register. The
    // check itself happens as a word leaves the input register, so the state
    // seen by the next word is always up to date.
    logic             r_in_valid;
    logic [SEQ_W-1:0] r_seq;
    logic             r_out_valid;
    t_verdict         r_verdict;

    logic             advance;
    logic             fire;
    t_verdict         verdict;

    // The verdict register can take a new word when it is empty or being read.
    assign advance     = !r_out_valid || i_verdict_ready;
    assign fire        = r_in_valid && advance;
    assign o_seq_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_seq_ready) begin
                r_in_valid <= i_seq_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        if (i_seq_valid && o_seq_ready) begin
            r_seq <= i_seq_number;
        end
        if (fire) begin
            r_verdict <= verdict;
        end
    end

    rwc_window u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_seq     (r_seq),
        .i_cfg     (r_cfg),
        .o_verdict (verdict)
    );

    assign o_verdict_valid = r_out_valid;
    assign o_verdict       = r_verdict;

endmodule

// File: sim/replay_window_check_tb.sv
// ----------------------------------------------------------------------------
// Replay window check testbench
// Sends sequence numbers through the valid/ready input channel and compares
// every verdict word with a cycle-free model of the anti-replay window. Both
// channels idle and stall at random. The window settings are changed between
// phases while the block is idle.
// ----------------------------------------------------------------------------
module replay_window_check_tb;
    import rwc_pkg::*;

    // ------------------------------------------------------------------------
    // Window model and verdict scoreboard.
    // The model holds its own copy of the highest number, the arrival bitmap
    // and both registers. Each accepted sequence number is judged at once.
    // The verdict is queued until the block returns its own.
    // ------------------------------------------------------------------------
    class window_tracker;
        logic [SEQ_W-1:0]      top_seq;
        logic [WINDOW_MAX-1:0] arrivals;
        logic                  enabled;
        logic [WIN_W-1:0]      window;
        t_verdict              expected_verdicts[$];
        int                    errors;
        int                    n_accept;
        int                    n_old;
        int                    n_dup;

        function new();
            top_seq  = '0;
            arrivals = '0;
            enabled  = 1'b0;
            window   = '0;
            errors   = 0;
            n_accept = 0;
            n_old    = 0;
            n_dup    = 0;
        endfunction

        function void write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] data);
            if (idx == REG_RX_ENABLE) begin
                enabled = data[0];
            end else if (idx == REG_WINDOW_SIZE) begin
                window = data[WIN_W-1:0];
            end
        endfunction

        // Window as the check uses it: anything above the bitmap size saturates.
        function int unsigned eff_window();
            return (window > WINDOW_MAX) ? WINDOW_MAX : window;
        endfunction

        // Judges one sequence number and queues the verdict it must produce.
        function void judge_seq(logic [SEQ_W-1:0] seq);
            logic [SEQ_W-1:0] behind;
            t_verdict         v;
            behind = '0;
            if (!enabled || window == '0) begin
                v = VERDICT_ACCEPT;
            end else begin
                if (seq > top_seq) begin
                    // A jump of the full bitmap length or more leaves nothing.
                    if (seq - top_seq >= WINDOW_MAX_SEQ) begin
                        arrivals = '0;
                    end else begin
                        arrivals = arrivals << (seq - top_seq);
                    end
                    top_seq = seq;
                end else begin
                    behind = top_seq - seq;
                end
                if (behind >= eff_window()) begin
                    v = VERDICT_OLD;
                end else if (arrivals[behind[IDX_W-1:0]]) begin
                    v = VERDICT_DUP;
                end else begin
                    arrivals[behind[IDX_W-1:0]] = 1'b1;
                    v = VERDICT_ACCEPT;
                end
            end
            expected_verdicts.push_back(v);
        endfunction

        function void check_verdict(logic [1:0] got);
            t_verdict want;
            if (expected_verdicts.size() == 0) begin
                $display("%0t: verdict %0d arrived with none expected", $time, got);
                errors++;
            end else begin
                want = expected_verdicts.pop_front();
                if (got !== want) begin
                    $display("%0t: verdict mismatch, expected %0d (%s), actual %0d",
                             $time, want, want.name(), got);
                    errors++;
                end
                case (want)
                    VERDICT_ACCEPT: n_accept++;
                    VERDICT_OLD:    n_old++;
                    default:        n_dup++;
                endcase
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block under test.
    // ------------------------------------------------------------------------
    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_wr_en;
    logic [CIDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]  i_cfg_wdata;
    logic              i_seq_valid;
    logic              o_seq_ready;
    logic [SEQ_W-1:0]  i_seq_number;
    logic              o_verdict_valid;
    logic              i_verdict_ready;
    logic [1:0]        o_verdict;

    window_tracker     board = new();
    logic [SEQ_W-1:0]  recent_seqs[$];
    int                items_sent = 0;
    bit                sender_busy_phase;

    always #10 i_clk = ~i_clk;

    replay_window_check dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_seq_valid     (i_seq_valid),
        .o_seq_ready     (o_seq_ready),
        .i_seq_number    (i_seq_number),
        .o_verdict_valid (o_verdict_valid),
        .i_verdict_ready (i_verdict_ready),
        .o_verdict       (o_verdict)
    );

    // Idle length: mostly none or short, now and then a long pause.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else begin
            return $urandom_range(6, 25);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Input side. Valid stays high from one word to the next when there is no
    // gap, so it is never lowered and raised in one time step. It is dropped
    // only when a gap starts or the stream pauses for a register write.
    // ------------------------------------------------------------------------
    task automatic send_seq(input logic [SEQ_W-1:0] seq);
        int gap;
        gap = sender_busy_phase ? 0 : pick_gap();
        if (gap > 0) begin
            i_seq_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_seq_valid  <= 1'b1;
        i_seq_number <= seq;
        @(posedge i_clk);
        while (!o_seq_ready) @(posedge i_clk);
        board.judge_seq(seq);
        recent_seqs.push_back(seq);
        if (recent_seqs.size() > 8) begin
            void'(recent_seqs.pop_front());
        end
        items_sent++;
    endtask

    // Stops the stream and waits until every verdict is back, plus a margin
    // for the two pipeline stages.
    task automatic drain();
        i_seq_valid <= 1'b0;
        while (board.expected_verdicts.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Writes both registers on back-to-back edges, so the write enable gets a
    // single assignment per step. The enable data carries junk in its upper
    // bits, which the block must ignore.
    task automatic set_window(input logic en, input logic [WIN_W-1:0] win);
        logic [CFG_W-1:0] en_word;
        en_word = CFG_W'($urandom_range(0, 127));
        en_word[0] = en;
        drain();
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= REG_RX_ENABLE;
        i_cfg_wdata <= en_word;
        @(posedge i_clk);
        board.write_reg(REG_RX_ENABLE, en_word);
        i_cfg_index <= REG_WINDOW_SIZE;
        i_cfg_wdata <= CFG_W'(win);
        @(posedge i_clk);
        board.write_reg(REG_WINDOW_SIZE, CFG_W'(win));
        i_cfg_wr_en <= 1'b0;
        sender_busy_phase = ($urandom_range(0, 3) == 0);
    endtask

    // Picks a number near the current top so that most words land on the
    // interesting edges: inside the window, on its boundary, repeats and
    // jumps around the bitmap length. With checking off the whole 32-bit
    // range is used, since the state cannot move then.
    function automatic logic [SEQ_W-1:0] pick_seq();
        logic [SEQ_W-1:0] top;
        int unsigned      win;
        int unsigned      back;
        int               r;
        top = board.top_seq;
        win = board.eff_window();
        if (win == 0) begin
            win = 1;
        end
        if (!board.enabled || board.window == '0) begin
            return $urandom();
        end
        r = $urandom_range(0, 99);
        if (r < 30) begin
            return top + $urandom_range(1, 4);
        end else if (r < 80 && r >= 55 && r < 62) begin
            back = win + $urandom_range(0, 2) - 1;
        end else if (r < 45) begin
            back = $urandom_range(0, win - 1);
        end else if (r < 55) begin
            if (recent_seqs.size() == 0) begin
                return top;
            end
            return recent_seqs[$urandom_range(0, recent_seqs.size() - 1)];
        end else if (r < 70) begin
            back = $urandom_range(win, 1000);
        end else if (r < 77) begin
            return top + $urandom_range(60, 70);
        end else if (r < 80) begin
            return top + $urandom_range(1000, 1 << 20);
        end else begin
            return top;
        end
        // Never step below zero; that would turn into a huge forward jump.
        if (back > top) begin
            back = top;
        end
        return top - back;
    endfunction

    // ------------------------------------------------------------------------
    // Output side: a stall counter drives ready. Some stretches never stall.
    // ------------------------------------------------------------------------
    initial begin
        int  stall_left;
        bit  steady;
        stall_left = 0;
        steady     = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_verdict_valid && i_verdict_ready) begin
                board.check_verdict(o_verdict);
            end
            if ($urandom_range(0, 199) == 0) begin
                steady = ~steady;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_verdict_ready <= 1'b0;
            end else begin
                i_verdict_ready <= 1'b1;
                if (!steady) begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    // Hard stop in case the handshake hangs.
    initial begin
        #5000000;
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        logic             phase_en[10];
        logic [WIN_W-1:0] phase_win[10];

        i_rst_n         <= 1'b0;
        i_cfg_wr_en     <= 1'b0;
        i_cfg_index     <= '0;
        i_cfg_wdata     <= '0;
        i_seq_valid     <= 1'b0;
        i_seq_number    <= '0;
        i_verdict_ready <= 1'b0;
        sender_busy_phase = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: protection off, so anything passes.
        send_seq(32'hFFFF_FFFF);
        send_seq(32'h0000_0000);

        // Protection on but a zero window still passes everything.
        set_window(1'b1, 7'd0);
        send_seq(32'hAAAA_AAAA);
        send_seq(32'h5555_5555);

        // Full window. Equal to the top hits bit 0; a jump of 63 keeps the old
        // bit at the far end; a jump of exactly 64 clears the bitmap.
        set_window(1'b1, 7'd64);
        send_seq(32'd0);
        send_seq(32'd0);
        send_seq(32'd63);
        send_seq(32'd0);
        send_seq(32'd127);
        send_seq(32'd63);
        send_seq(32'd64);
        send_seq(32'd64);
        send_seq(32'd200);
        send_seq(32'd137);
        send_seq(32'd136);
        send_seq(32'd200);

        // A window above the bitmap size behaves as the full bitmap.
        set_window(1'b1, 7'd127);
        send_seq(32'd137);
        send_seq(32'd136);
        send_seq(32'd150);

        // A narrow window: distance equal to the window is too old, and bits
        // left beyond it from the wide window are never looked at.
        set_window(1'b1, 7'd4);
        send_seq(32'd197);
        send_seq(32'd196);
        send_seq(32'd150);

        // Random phases across the range of settings.
        phase_en  = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1};
        phase_win = '{7'd64, 7'd8, 7'd1, 7'd32, 7'd127, 7'd0, 7'd100, 7'd17, 7'd2, 7'd64};
        for (int p = 0; p < 10; p++) begin
            set_window(phase_en[p], phase_win[p]);
            for (int k = 0; k < 40; k++) begin
                send_seq(pick_seq());
            end
        end

        // The top of the number space, left for last since the highest
        // number can never come back down.
        set_window(1'b1, 7'd64);
        send_seq(32'hFFFF_FFFF);
        send_seq(32'hFFFF_FFFF);
        send_seq(32'hFFFF_FFC0);
        send_seq(32'hFFFF_FFBF);

        drain();
        repeat (10) @(posedge i_clk);
        if (board.expected_verdicts.size() != 0) begin
            $display("%0t: %0d verdicts never arrived", $time,
                     board.expected_verdicts.size());
            board.errors++;
        end

        $display("Checked %0d sequence numbers over 16 window settings.", items_sent);
        $display("Verdicts seen: %0d accepted, %0d too old, %0d repeated.",
                 board.n_accept, board.n_old, board.n_dup);
        if (board.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
